[rtl/assert_macros.svh]
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_SAME(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("check failed");

// next-cycle implication, off during reset
`define CHK_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("check failed");

// condition that must follow a reset cycle
`define CHK_RESET(lbl, c) \
   lbl: assert property (@(posedge clock) reset |=> (c)) \
      else $error("check failed after reset");

`endif

[rtl/plps_pkg.sv]
`timescale 1ns / 1ps
package plps_pkg;

   // field widths
   localparam int VW = 17;   // Q1.16 node and output values
   localparam int PW = 24;   // Q0.24 phase fraction
   localparam int SW = 24;   // sync multiplier
   localparam int XPW = 32;  // phase field

   localparam int DEF_MAX_NODES = 32;

   localparam logic [VW-1:0] ONE_Q16 = 17'd65536;
   localparam logic [VW-1:0] HALF_Q16 = 17'd32768;

   // opcodes
   localparam logic OP_EVAL = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // control broadcast to every node cell
   typedef struct packed {
      logic          ins;
      logic          cmt;
      logic [VW-1:0] x;
      logic [VW-1:0] y;
   } plps_ctl_type;

endpackage

[rtl/plps_cell.sv]
`timescale 1ns / 1ps
module plps_cell import plps_pkg::*; #(
   parameter logic [VW-1:0] INIT_X = '0,
   parameter logic [VW-1:0] INIT_Y = '0
) (
   input  logic          clock,
   input  logic          reset,
   input  plps_ctl_type  ctl,
   input  logic          in_list,
   input  logic          left_keep,
   input  logic [VW-1:0] left_x,
   input  logic [VW-1:0] left_y,
   output logic          keep,
   output logic [VW-1:0] sh_x,
   output logic [VW-1:0] sh_y,
   input  logic          seg_ok,
   input  logic [PW-1:0] s,
   input  logic [VW-1:0] right_x,
   output logic [VW-1:0] act_x,
   output logic [VW-1:0] act_y,
   output logic          hit
);

   logic [VW-1:0] sh_x_ff, sh_y_ff;
   logic [VW-1:0] act_x_ff, act_y_ff;

   // node stays if it sorts at or before the new one
   assign keep = in_list && (sh_x_ff <= ctl.x);

   // shadow node: keep, take the new node, or take the left neighbor
   always_ff @(posedge clock) begin
      if (ctl.ins && !keep) begin
         sh_x_ff <= left_keep ? ctl.x : left_x;
         sh_y_ff <= left_keep ? ctl.y : left_y;
      end
   end

   // active node, copied from shadow on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         act_x_ff <= INIT_X;
         act_y_ff <= INIT_Y;
      end else if (ctl.cmt) begin
         act_x_ff <= sh_x_ff;
         act_y_ff <= sh_y_ff;
      end
   end

   // segment from this node to the right neighbor brackets s
   assign hit = seg_ok && ({1'b0, s} >= {act_x_ff, 8'd0}) && ({1'b0, s} <= {right_x, 8'd0});

   assign sh_x  = sh_x_ff;
   assign sh_y  = sh_y_ff;
   assign act_x = act_x_ff;
   assign act_y = act_y_ff;

endmodule

[rtl/plps_div.sv]
`timescale 1ns / 1ps
module plps_div import plps_pkg::*; #(
   parameter int NW = 43,
   parameter int DW = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);

   localparam int CNTW = $clog2(NW + 1);

   logic [DW-1:0]   rem_ff, rem_in;
   logic [NW-1:0]   quo_ff, quo_in;
   logic [DW-1:0]   den_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic [DW:0]     trial;
   logic            ge;

   // one restoring step per cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[NW-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
      quo_in = {quo_ff[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNTW'(NW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

[rtl/piecewise_linear_phase_shaper.sv]
`timescale 1ns / 1ps
// Piecewise linear curve shaper for a phase signal.
// Request channel (req_valid / req_stall): opcode load puts node_x, node_y
// into a shadow list kept sorted by a row of node cells; first_node empties
// the list, last_node copies it into the active table. Opcode evaluate
// wraps phase, scales it by sync, interpolates the active curve and blends
// the phase toward the result by depth.
// Response channel (rsp_valid / rsp_stall): one value per evaluate, none
// per load.
// Sequence: a load without last_node leaves the block idle; one with it
// adds a commit step. An evaluate passes sync multiply, cell search,
// segment select, divider start, bit-serial divide and blend before its
// response is registered; the next request is taken once it is. With a
// zero-width segment or fewer than two active nodes the divide is skipped.
// The serial divider sets the evaluate rate; one item is in work at a time.
// A finished response waits in the output register while the receiver
// stalls; new requests are taken meanwhile, and an evaluate that finishes
// while the old response is still stalled holds until it is taken.
// Reset: the active table becomes the identity line (0,0)-(1,1), the
// shadow list is empty, and no response is pending.
module piecewise_linear_phase_shaper import plps_pkg::*; #(
   parameter int MAX_NODES = DEF_MAX_NODES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           req_opcode,
   input  logic [XPW-1:0] req_phase,
   input  logic [SW-1:0]  req_sync,
   input  logic [VW-1:0]  req_depth,
   input  logic [VW-1:0]  req_node_x,
   input  logic [VW-1:0]  req_node_y,
   input  logic           req_first_node,
   input  logic           req_last_node,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [VW-1:0]  rsp_value
);

   localparam int CW   = $clog2(MAX_NODES + 1);
   localparam int NUMW = 44;
   localparam int MAGW = NUMW - 1;
   localparam int DENW = VW + 8;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_COMMIT = 3'd1;
   localparam logic [2:0] ST_SYNC   = 3'd2;
   localparam logic [2:0] ST_SEARCH = 3'd3;
   localparam logic [2:0] ST_SELECT = 3'd4;
   localparam logic [2:0] ST_DSTART = 3'd5;
   localparam logic [2:0] ST_DIVIDE = 3'd6;
   localparam logic [2:0] ST_MIX    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       finish_ff;

   logic [CW-1:0] sh_cnt_ff, act_cnt_ff, sh_eff;
   logic          full;
   logic          acc, load_acc;

   logic [PW-1:0]   p_ff, s_ff;
   logic [SW-1:0]   sync_ff;
   logic [VW-1:0]   depth_ff;
   logic [MAX_NODES-1:0] hit, hit_ff, first;
   logic signed [NUMW-1:0] num_ff;
   logic [DENW-1:0] den_ff;
   logic [VW-1:0]   y1_ff;
   logic            half_ff;
   logic signed [NUMW-1:0] mix_ff;
   logic            rsp_valid_ff;
   logic [VW-1:0]   rsp_value_ff;

   plps_ctl_type ctl;

   logic [VW-1:0] sh_x [MAX_NODES];
   logic [VW-1:0] sh_y [MAX_NODES];
   logic [VW-1:0] act_x [MAX_NODES];
   logic [VW-1:0] act_y [MAX_NODES];
   logic [VW-1:0] nx_x [MAX_NODES];
   logic [VW-1:0] nx_y [MAX_NODES];
   logic [MAX_NODES-1:0] keep;

   logic          div_busy;
   logic [MAGW-1:0] div_quo;
   logic [MAGW-1:0] num_mag;

   // handshake and shadow count bookkeeping
   assign acc       = req_valid && !req_stall;
   assign load_acc  = acc && (req_opcode == OP_LOAD);
   assign sh_eff    = req_first_node ? '0 : sh_cnt_ff;
   assign full      = sh_eff >= CW'(MAX_NODES);
   assign req_stall = (state_ff != ST_IDLE) || finish_ff;

   assign ctl.ins = load_acc && !full;
   assign ctl.cmt = (state_ff == ST_COMMIT);
   assign ctl.x   = req_node_x;
   assign ctl.y   = req_node_y;

   // row of node cells
   for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
      logic          lk;
      logic [VW-1:0] lx, ly;
      if (i == 0) begin : g_first
         assign lk = 1'b1;
         assign lx = '0;
         assign ly = '0;
      end else begin : g_mid
         assign lk = keep[i-1];
         assign lx = sh_x[i-1];
         assign ly = sh_y[i-1];
      end
      if (i == MAX_NODES - 1) begin : g_last
         assign nx_x[i] = '0;
         assign nx_y[i] = '0;
      end else begin : g_next
         assign nx_x[i] = act_x[i+1];
         assign nx_y[i] = act_y[i+1];
      end
      plps_cell #(
         .INIT_X((i == 1) ? ONE_Q16 : '0),
         .INIT_Y((i == 1) ? ONE_Q16 : '0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_list   (CW'(i) < sh_eff),
         .left_keep (lk),
         .left_x    (lx),
         .left_y    (ly),
         .keep      (keep[i]),
         .sh_x      (sh_x[i]),
         .sh_y      (sh_y[i]),
         .seg_ok    ((CW + 1)'(i + 1) < {1'b0, act_cnt_ff}),
         .s         (s_ff),
         .right_x   (nx_x[i]),
         .act_x     (act_x[i]),
         .act_y     (act_y[i]),
         .hit       (hit[i])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_opcode == OP_LOAD) begin
                  state_in = req_last_node ? ST_COMMIT : ST_IDLE;
               end else begin
                  state_in = ST_SYNC;
               end
            end
         end
         ST_COMMIT: state_in = ST_IDLE;
         ST_SYNC:   state_in = ST_SEARCH;
         ST_SEARCH: state_in = ST_SELECT;
         ST_SELECT: state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIVIDE;
         ST_DIVIDE: state_in = div_busy ? ST_DIVIDE : ST_MIX;
         ST_MIX:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         finish_ff  <= 1'b0;
         sh_cnt_ff  <= '0;
         act_cnt_ff <= CW'(2);
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MIX) begin
            finish_ff <= 1'b1;
         end else if (finish_ff && !(rsp_valid_ff && rsp_stall)) begin
            finish_ff <= 1'b0;
         end
         if (load_acc) begin
            sh_cnt_ff <= sh_eff + CW'(!full);
         end
         if (state_ff == ST_COMMIT) begin
            act_cnt_ff <= sh_cnt_ff;
         end
      end
   end

   // evaluate datapath
   always_comb begin
      first = hit_ff & ~(hit_ff - 1'b1);
      if (hit_ff == '0) begin
         first = MAX_NODES'(1);
      end
   end

   always_ff @(posedge clock) begin
      logic [VW-1:0] x1, y1, x2, y2;
      logic signed [VW:0]   dy;
      logic signed [DENW:0] sd;
      x1 = '0;
      y1 = '0;
      x2 = '0;
      y2 = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         if (first[i]) begin
            x1 = x1 | act_x[i];
            y1 = y1 | act_y[i];
            x2 = x2 | nx_x[i];
            y2 = y2 | nx_y[i];
         end
      end
      dy = $signed({1'b0, y2}) - $signed({1'b0, y1});
      sd = $signed({2'b0, s_ff}) - $signed({1'b0, x1, 8'd0});

      if (acc && (req_opcode == OP_EVAL)) begin
         p_ff     <= req_phase[PW-1:0];
         sync_ff  <= req_sync;
         depth_ff <= req_depth;
      end
      if (state_ff == ST_SYNC) begin
         s_ff <= PW'(({24'd0, p_ff} * {24'd0, sync_ff}) >> 16);
      end
      if (state_ff == ST_SEARCH) begin
         hit_ff <= hit;
      end
      if (state_ff == ST_SELECT) begin
         num_ff  <= NUMW'(dy * sd);
         den_ff  <= {x2, 8'd0} - {x1, 8'd0};
         y1_ff   <= y1;
         half_ff <= act_cnt_ff < CW'(2);
      end
   end

   assign num_mag = num_ff[NUMW-1] ? MAGW'(-num_ff) : MAGW'(num_ff);

   // no divide on den zero or a short table, whose second entry may be unloaded
   plps_div #(.NW(MAGW), .DW(DENW)) u_div (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_DSTART) && !half_ff && (den_ff != '0)),
      .num   (num_mag),
      .den   (den_ff),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // curve value, clamp, and depth product
   always_ff @(posedge clock) begin
      logic signed [NUMW-1:0] q;
      logic signed [NUMW+1:0] v;
      logic [VW-1:0]          raw;
      logic signed [DENW:0]   diff;
      q = (den_ff == '0) ? '0 :
          (num_ff[NUMW-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo}));
      v = $signed({{(NUMW-VW+1){1'b0}}, y1_ff}) + (NUMW+2)'(q);
      if (half_ff) begin
         raw = HALF_Q16;
      end else if (v < 0) begin
         raw = '0;
      end else if (v > $signed({{(NUMW-VW+1){1'b0}}, ONE_Q16})) begin
         raw = ONE_Q16;
      end else begin
         raw = v[VW-1:0];
      end
      diff = $signed({1'b0, raw, 8'd0}) - $signed({2'b0, p_ff});
      if (state_ff == ST_MIX) begin
         mix_ff <= NUMW'($signed({1'b0, depth_ff}) * diff);
      end
   end

   // blend, clamp and response register
   always_ff @(posedge clock) begin
      logic signed [NUMW-1:0] rnd;
      logic signed [28:0]     r;
      rnd = mix_ff + (mix_ff[NUMW-1] ? NUMW'(65535) : NUMW'(0));
      r   = $signed({5'd0, p_ff}) + 29'(rnd >>> 16);
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_ff && !(rsp_valid_ff && rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
         if (r < 0) begin
            rsp_value_ff <= '0;
         end else if (r > 29'sd16777216) begin
            rsp_value_ff <= ONE_Q16;
         end else begin
            rsp_value_ff <= r[24:8];
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

[rtl/plps_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plps_checker import plps_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          req_opcode,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [VW-1:0] rsp_value
);

   // a stalled response stays up
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   // a valid output never exceeds one
   `CHK_SAME(a_rsp_range, rsp_valid, rsp_value <= ONE_Q16)
   // an evaluate transfer keeps the block busy next cycle
   `CHK_NEXT(a_eval_busy, req_valid && !req_stall && (req_opcode == OP_EVAL), req_stall)
   // a new response only appears while requests are held off
   `CHK_SAME(a_rsp_rise, $rose(rsp_valid), $past(req_stall))
   // nothing pending after reset
   `CHK_RESET(a_reset_idle, !rsp_valid)

endmodule

bind piecewise_linear_phase_shaper plps_checker u_plps_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import plps_pkg::*;

   localparam int NODES = DEF_MAX_NODES;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic           op;
      logic [XPW-1:0] phase;
      logic [SW-1:0]  sync;
      logic [VW-1:0]  depth;
      logic [VW-1:0]  nx;
      logic [VW-1:0]  ny;
      logic           first;
      logic           last;
   } shaper_req_type;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_stall;
   logic           req_opcode;
   logic [XPW-1:0] req_phase;
   logic [SW-1:0]  req_sync;
   logic [VW-1:0]  req_depth;
   logic [VW-1:0]  req_node_x;
   logic [VW-1:0]  req_node_y;
   logic           req_first_node;
   logic           req_last_node;
   logic           rsp_valid;
   logic           rsp_stall;
   logic [VW-1:0]  rsp_value;

   piecewise_linear_phase_shaper u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_phase(req_phase), .req_sync(req_sync),
      .req_depth(req_depth), .req_node_x(req_node_x), .req_node_y(req_node_y),
      .req_first_node(req_first_node), .req_last_node(req_last_node),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value)
   );

   // predicted curve tables
   logic [VW-1:0] curve_x[NODES];
   logic [VW-1:0] curve_y[NODES];
   int            curve_count;
   logic [VW-1:0] pending_x[NODES];
   logic [VW-1:0] pending_y[NODES];
   int            pending_count;

   logic [VW-1:0] expected_values[$];
   int            error_count = 0;
   int            evals_sent = 0;
   int            loads_sent = 0;
   int            values_checked = 0;
   int            burst_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4ms;
      $display("testbench: errors");
      $finish;
   end

   // blended curve value for one evaluate
   function automatic logic [VW-1:0] blended_value(logic [XPW-1:0] ph, logic [SW-1:0] sy,
                                                    logic [VW-1:0] dp);
      longint p, s, raw, lo, hi, x1, y1, x2, y2, den, r;
      int seg;
      p = longint'(ph[PW-1:0]);
      s = ((p * longint'(sy)) >>> 16) & 64'hFF_FFFF;
      if (curve_count < 2 || curve_count > NODES) begin
         raw = 32768;
      end else begin
         seg = 0;
         // first bracketing segment, else segment 0 extrapolated
         for (int j = 0; j + 1 < curve_count; j++) begin
            lo = longint'(curve_x[j]) << 8;
            hi = longint'(curve_x[j+1]) << 8;
            if (s >= lo && s <= hi) begin
               seg = j;
               break;
            end
         end
         x1 = longint'(curve_x[seg]) * 256;
         y1 = longint'(curve_y[seg]);
         x2 = longint'(curve_x[seg+1]) * 256;
         y2 = longint'(curve_y[seg+1]);
         den = x2 - x1;
         if (den == 0) raw = y1;
         else raw = y1 + ((y2 - y1) * (s - x1)) / den;
         if (raw < 0) raw = 0;
         if (raw > 65536) raw = 65536;
      end
      // blend toward curve by depth
      r = p + (longint'(dp) * (raw * 256 - p)) / 65536;
      if (r < 0) r = 0;
      if (r > 64'd16777216) r = 64'd16777216;
      return VW'(r >>> 8);
   endfunction

   // node insert into the pending list, commit on last node
   task automatic load_node(shaper_req_type it);
      int pos;
      if (it.first) pending_count = 0;
      if (pending_count < NODES) begin
         pos = 0;
         while (pos < pending_count && pending_x[pos] <= it.nx) pos++;
         for (int k = pending_count; k > pos; k--) begin
            pending_x[k] = pending_x[k-1];
            pending_y[k] = pending_y[k-1];
         end
         pending_x[pos] = it.nx;
         pending_y[pos] = it.ny;
         pending_count++;
      end
      if (it.last && pending_count > 0) begin
         curve_x = pending_x;
         curve_y = pending_y;
         curve_count = pending_count;
      end
   endtask

   // one request transfer, with burst gaps
   task automatic send(shaper_req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= it.op;
      req_phase      <= it.phase;
      req_sync       <= it.sync;
      req_depth      <= it.depth;
      req_node_x     <= it.nx;
      req_node_y     <= it.ny;
      req_first_node <= it.first;
      req_last_node  <= it.last;
      do @(posedge clock); while (req_stall);
      if (it.op == OP_EVAL) begin
         expected_values.push_back(blended_value(it.phase, it.sync, it.depth));
         evals_sent++;
      end else begin
         load_node(it);
         loads_sent++;
      end
   endtask

   // random item, fields random, depth and node values mostly in range
   function automatic shaper_req_type random_req(logic op);
      shaper_req_type it;
      it.op = op;
      it.phase = $urandom;
      it.sync = SW'($urandom);
      case ($urandom_range(0, 5))
         0: it.depth = 17'd0;
         1: it.depth = ONE_Q16;
         2: it.depth = VW'($urandom);
         default: it.depth = VW'($urandom_range(0, 65536));
      endcase
      it.nx = ($urandom_range(0, 9) == 0) ? VW'($urandom) : VW'($urandom_range(0, 65536));
      it.ny = ($urandom_range(0, 9) == 0) ? VW'($urandom) : VW'($urandom_range(0, 65536));
      it.first = 1'($urandom);
      it.last = 1'($urandom);
      return it;
   endfunction

   task automatic eval_at(logic [XPW-1:0] ph, logic [SW-1:0] sy, logic [VW-1:0] dp);
      shaper_req_type it;
      it = random_req(OP_EVAL);
      it.phase = ph;
      it.sync = sy;
      it.depth = dp;
      send(it);
   endtask

   task automatic load_at(logic [VW-1:0] x, logic [VW-1:0] y, logic f, logic l);
      shaper_req_type it;
      it = random_req(OP_LOAD);
      it.nx = x;
      it.ny = y;
      it.first = f;
      it.last = l;
      send(it);
   endtask

   // identity table after reset, field extremes
   task automatic test_reset_curve();
      eval_at(32'h0000_0000, 24'h01_0000, ONE_Q16);
      eval_at(32'hFFFF_FFFF, 24'h01_0000, ONE_Q16);
      eval_at(32'h8000_0000, 24'hFF_FFFF, 17'd0);
      eval_at(32'h7FFF_FFFF, 24'h00_0000, 17'h1_FFFF);
      eval_at(32'h0080_0000, 24'h02_8000, 17'd32768);
   endtask

   // single committed node gives one half
   task automatic test_single_node();
      load_at(17'd30000, 17'd1000, 1'b1, 1'b1);
      eval_at(32'h0040_0000, 24'h01_0000, ONE_Q16);
      eval_at(32'h00C0_0000, 24'h01_0000, 17'd20000);
   endtask

   // out-of-order nodes, equal x ties, zero-width segment
   task automatic test_sorted_ties();
      load_at(17'd49152, 17'd60000, 1'b1, 1'b0);
      load_at(17'd16384, 17'd5000, 1'b0, 1'b0);
      load_at(17'd16384, 17'd40000, 1'b0, 1'b0);
      load_at(17'd65536, 17'd0, 1'b0, 1'b1);
      eval_at(32'h0040_0000, 24'h01_0000, ONE_Q16);
      eval_at(32'h0060_0000, 24'h01_0000, ONE_Q16);
      eval_at(32'h00E0_0000, 24'h01_0000, ONE_Q16);
   endtask

   // curve not reaching zero: extrapolation, out-of-range nodes
   task automatic test_extrapolate();
      load_at(17'd40000, 17'h1_FFFF, 1'b1, 1'b0);
      load_at(17'h1_FFFF, 17'd10, 1'b0, 1'b1);
      eval_at(32'h0010_0000, 24'h01_0000, ONE_Q16);
      eval_at(32'h00F0_0000, 24'h01_0000, 17'h1_FFFF);
   endtask

   // overfull list: dropped nodes, last one still commits
   task automatic test_full_list();
      for (int k = 0; k < NODES + 2; k++)
         load_at(VW'($urandom_range(0, 65536)), VW'($urandom_range(0, 65536)),
                 k == 0, k == NODES + 1);
      eval_at($urandom, 24'h01_0000, ONE_Q16);
      eval_at($urandom, SW'($urandom), VW'($urandom_range(0, 65536)));
   endtask

   // well-formed node lists with evaluates, plus noise
   task automatic test_random_traffic(int total);
      int sent, n;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 9))
            0: begin
               // stray or broken loads
               send(random_req(OP_LOAD));
               sent++;
            end
            1, 2: begin
               n = ($urandom_range(0, 15) == 0) ? $urandom_range(NODES - 1, NODES + 3)
                                                : $urandom_range(1, 8);
               for (int k = 0; k < n; k++) begin
                  shaper_req_type it;
                  it = random_req(OP_LOAD);
                  // few distinct x values so ties happen
                  if ($urandom_range(0, 3) == 0) it.nx = VW'($urandom_range(0, 4) * 16384);
                  it.first = (k == 0);
                  it.last = (k == n - 1);
                  send(it);
               end
               sent += n;
            end
            default: begin
               shaper_req_type it;
               n = $urandom_range(1, 8);
               for (int k = 0; k < n; k++) begin
                  it = random_req(OP_EVAL);
                  if ($urandom_range(0, 2) == 0) it.sync = 24'h01_0000;
                  send(it);
               end
               sent += n;
            end
         endcase
      end
   endtask

   // receiver stall pattern
   int stall_left = 0;
   int stall_kind = 0;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 120);
      end
      stall_left--;
      case (stall_kind)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom);
         2: rsp_stall <= (stall_left % 40) < 30;
         default: rsp_stall <= stall_left[0];
      endcase
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            $error("value: response with none expected, actual %0d", rsp_value);
            error_count++;
         end else begin
            logic [VW-1:0] want;
            want = expected_values.pop_front();
            if (rsp_value !== want) begin
               $error("value: expected %0d, actual %0d", want, rsp_value);
               error_count++;
            end
            values_checked++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_EVAL;
      req_phase = '0;
      req_sync = '0;
      req_depth = '0;
      req_node_x = '0;
      req_node_y = '0;
      req_first_node = 1'b0;
      req_last_node = 1'b0;
      for (int k = 0; k < NODES; k++) begin
         curve_x[k] = '0;
         curve_y[k] = '0;
         pending_x[k] = '0;
         pending_y[k] = '0;
      end
      curve_x[1] = ONE_Q16;
      curve_y[1] = ONE_Q16;
      curve_count = 2;
      pending_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_curve();
      test_single_node();
      test_sorted_ties();
      test_extrapolate();
      test_full_list();
      test_random_traffic(1250);

      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_values.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d evaluates and %0d node loads, %0d values checked",
               evals_sent, loads_sent, values_checked);
      $display("including short, single-node, tied, overfull and out-of-range curves");
      if (error_count == 0 && expected_values.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/plps_pkg.sv
rtl/plps_cell.sv
rtl/plps_div.sv
rtl/piecewise_linear_phase_shaper.sv
rtl/plps_checker.sv
tb/testbench.sv
